@@ design/tcce_pkg.sv @@
// Shared constants, payload types and queue entry type of the text console cursor engine.
`default_nettype none

package tcce_pkg;

  // Screen geometry
  localparam int NUM_COLS   = 80;
  localparam int NUM_ROWS   = 25;
  localparam int CELL_COUNT = NUM_ROWS * NUM_COLS;

  // Field widths
  localparam int ROW_W  = 5;
  localparam int COL_W  = 7;
  localparam int IDX_W  = 11;
  localparam int CELL_W = 16;
  localparam int ATTR_W = 8;
  localparam int CHAR_W = 8;

  localparam logic [ATTR_W-1:0] DEFAULT_ATTR_RST = 8'h07;

  // Command codes
  localparam logic [1:0] CMD_PUT   = 2'd0;
  localparam logic [1:0] CMD_CLEAR = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  // Character codes
  localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_LAST  = 8'h7F;

  localparam int TAB_STEP = 4;

  typedef struct packed {
    logic [1:0]        command;
    logic [CHAR_W-1:0] char_code;
    logic [ATTR_W-1:0] color;
    logic [IDX_W-1:0]  cell_index;
  } in_item_t;

  typedef struct packed {
    logic [ROW_W-1:0]  row_after;
    logic [COL_W-1:0]  col_after;
    logic [CELL_W-1:0] cell_data;
    logic              scrolled;
  } out_item_t;

  // What the back end has to do for one transaction
  typedef enum logic [1:0] {
    K_NOP,
    K_WRITE,
    K_READ,
    K_CLEAR
  } op_kind_t;

  typedef struct packed {
    op_kind_t          kind;
    logic              scroll;
    logic [IDX_W-1:0]  addr;
    logic [CELL_W-1:0] wdata;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
  } tcce_op_t;

endpackage

`default_nettype wire

@@ design/text_console_cursor_engine.sv @@
// Top level of the character-cell text console: config register, front end, op queue, back end.
`default_nettype none

// Character-cell text console of 25 rows by 80 columns with a cursor. A
// transaction is taken when start is high and busy is low; it puts one
// character (control codes backspace, tab, newline and carriage return are
// interpreted), clears the screen, or reads one cell. Every transaction gives
// exactly one result, shown for one cycle with out_strobe high; the receiver
// cannot hold it off. The front end moves the cursor and hands one op per
// transaction to a two-entry queue, so busy rises only when that queue is
// full. The back end owns the 2000-cell screen store (one write and one
// registered read port) and sets the pace: a write or ignored byte takes only
// the pop, a read adds the registered read, a clear blanks one cell per cycle
// after the pop, and a scrolling put writes the character, copies 1920 cells
// up one row, drains the last copy and blanks the 80 bottom-row cells. The
// result is registered and appears in the cycle after the back end finishes
// its op. Read the screen only after a clear or after writing the cell. Write
// cfg_data only while no transaction is outstanding; cfg_ready is always high.
module text_console_cursor_engine
  import tcce_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire in_item_t          in_item,
  output logic                   out_strobe,
  output out_item_t              out_res,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [ATTR_W-1:0] cfg_data
);

  logic [ATTR_W-1:0] cfg_attr_r;
  logic              q_push, q_pop, q_full, q_empty;
  tcce_op_t          q_in, q_head;

  // Accept every configuration transaction; the block is idle by contract.
  assign cfg_ready = 1'b1;
  assign busy      = q_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_attr_r <= DEFAULT_ATTR_RST;
    end else if (cfg_valid && cfg_ready) begin
      cfg_attr_r <= cfg_data;
    end
  end

  tcce_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .in_item  (in_item),
    .cfg_attr (cfg_attr_r),
    .q_full   (q_full),
    .push     (q_push),
    .op       (q_in)
  );

  tcce_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .push_op (q_in),
    .pop     (q_pop),
    .head    (q_head),
    .full    (q_full),
    .empty   (q_empty)
  );

  tcce_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (q_head),
    .q_empty    (q_empty),
    .cfg_attr   (cfg_attr_r),
    .pop        (q_pop),
    .out_strobe (out_strobe),
    .out_res    (out_res)
  );

endmodule

`default_nettype wire

@@ design/tcce_front.sv @@
// Front end: accepts transactions, keeps the cursor and turns each transaction into a back-end op.
`default_nettype none

module tcce_front
  import tcce_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire in_item_t          in_item,
  input  wire logic [ATTR_W-1:0] cfg_attr,
  input  wire logic              q_full,
  output logic                   push,
  output tcce_op_t               op
);

  logic [ROW_W-1:0] cur_row_r, cur_row_nxt;
  logic [COL_W-1:0] cur_col_r, cur_col_nxt;

  logic [ROW_W:0]   row_t;
  logic [COL_W:0]   col_t;
  logic [ROW_W-1:0] wr_row;
  logic [COL_W-1:0] wr_col;
  logic             do_write;
  logic [CELL_W-1:0] wr_data;
  logic             scroll;

  assign push = start && !q_full;

  always_comb begin
    row_t    = {1'b0, cur_row_r};
    col_t    = {1'b0, cur_col_r};
    wr_row   = cur_row_r;
    wr_col   = cur_col_r;
    do_write = 1'b0;
    wr_data  = {in_item.color, in_item.char_code};
    case (in_item.char_code)
      CH_LF: begin
        col_t = '0;
        row_t = row_t + 1'b1;
      end
      CH_CR: begin
        col_t = '0;
      end
      CH_TAB: begin
        col_t = (col_t + (COL_W+1)'(TAB_STEP)) & ~(COL_W+1)'(TAB_STEP - 1);
      end
      CH_BS: begin
        if (cur_row_r != '0 || cur_col_r != '0) begin
          if (cur_col_r != '0) begin
            col_t  = col_t - 1'b1;
            wr_col = cur_col_r - 1'b1;
          end else begin
            row_t  = row_t - 1'b1;
            col_t  = (COL_W+1)'(NUM_COLS - 1);
            wr_row = cur_row_r - 1'b1;
            wr_col = COL_W'(NUM_COLS - 1);
          end
          do_write = 1'b1;
          wr_data  = {cfg_attr, CH_SPACE};
        end
      end
      default: begin
        if (in_item.char_code inside {[CH_SPACE:CH_LAST]}) begin
          do_write = 1'b1;
          col_t    = col_t + 1'b1;
        end
      end
    endcase
    // wrap at the line end, then scroll at the bottom
    if (col_t >= (COL_W+1)'(NUM_COLS)) begin
      col_t = '0;
      row_t = row_t + 1'b1;
    end
    scroll = 1'b0;
    if (row_t >= (ROW_W+1)'(NUM_ROWS)) begin
      scroll = 1'b1;
      row_t  = (ROW_W+1)'(NUM_ROWS - 1);
      col_t  = '0;
    end
  end

  always_comb begin
    op          = '0;
    op.kind     = K_NOP;
    op.row      = cur_row_r;
    op.col      = cur_col_r;
    cur_row_nxt = cur_row_r;
    cur_col_nxt = cur_col_r;
    case (in_item.command)
      CMD_PUT: begin
        op.kind     = do_write ? K_WRITE : K_NOP;
        op.scroll   = scroll;
        op.addr     = IDX_W'(wr_row) * IDX_W'(NUM_COLS) + IDX_W'(wr_col);
        op.wdata    = wr_data;
        cur_row_nxt = row_t[ROW_W-1:0];
        cur_col_nxt = col_t[COL_W-1:0];
      end
      CMD_CLEAR: begin
        op.kind     = K_CLEAR;
        cur_row_nxt = '0;
        cur_col_nxt = '0;
      end
      CMD_READ: begin
        // out-of-range reads answer zero without touching the store
        op.kind = (in_item.cell_index < IDX_W'(CELL_COUNT)) ? K_READ : K_NOP;
        op.addr = in_item.cell_index;
      end
      default: begin
        op.kind = K_NOP;
      end
    endcase
    op.row = cur_row_nxt;
    op.col = cur_col_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_row_r <= '0;
      cur_col_r <= '0;
    end else if (push) begin
      cur_row_r <= cur_row_nxt;
      cur_col_r <= cur_col_nxt;
    end
  end

  a_cursor_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cur_row_r < ROW_W'(NUM_ROWS)) && (cur_col_r < COL_W'(NUM_COLS)))
    else $error("cursor left the screen");

endmodule

`default_nettype wire

@@ design/tcce_queue.sv @@
// Two-entry op queue between the front end and the back end.
`default_nettype none

module tcce_queue
  import tcce_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     push,
  input  wire tcce_op_t push_op,
  input  wire logic     pop,
  output tcce_op_t      head,
  output logic          full,
  output logic          empty
);

  localparam int Q_DEPTH = 2;
  localparam int PTR_W   = $clog2(Q_DEPTH);
  localparam int CNT_W   = $clog2(Q_DEPTH + 1);

  tcce_op_t          entry_r [Q_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]  count_r;

  assign full  = (count_r == CNT_W'(Q_DEPTH));
  assign empty = (count_r == '0);
  assign head  = entry_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ design/tcce_back.sv @@
// Back end: owns the screen store and carries out writes, reads, clears and scrolls.
`default_nettype none

module tcce_back
  import tcce_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire tcce_op_t          head,
  input  wire logic              q_empty,
  input  wire logic [ATTR_W-1:0] cfg_attr,
  output logic                   pop,
  output logic                   out_strobe,
  output out_item_t              out_res
);

  localparam int LAST_COPY = CELL_COUNT - NUM_COLS - 1;

  typedef enum logic [2:0] {
    B_IDLE,
    B_READ,
    B_CLEAR,
    B_COPY,
    B_BLANK
  } back_state_t;

  back_state_t       state_r, state_nxt;
  tcce_op_t          cur_r, cur_nxt;
  logic [IDX_W-1:0]  sw_r, sw_nxt;
  logic              pend_r, pend_nxt;
  logic [IDX_W-1:0]  pend_addr_r, pend_addr_nxt;
  logic              out_strobe_r, out_strobe_nxt;
  out_item_t         out_res_r, out_res_nxt;

  logic [CELL_W-1:0] mem [CELL_COUNT];
  logic [CELL_W-1:0] rd_data_r;
  logic              we;
  logic [IDX_W-1:0]  waddr, raddr;
  logic [CELL_W-1:0] wdata;
  logic [CELL_W-1:0] blank;

  assign blank      = {cfg_attr, CH_SPACE};
  assign out_strobe = out_strobe_r;
  assign out_res    = out_res_r;

  always_comb begin
    state_nxt      = state_r;
    cur_nxt        = cur_r;
    sw_nxt         = sw_r;
    pend_nxt       = 1'b0;
    pend_addr_nxt  = pend_addr_r;
    out_strobe_nxt = 1'b0;
    out_res_nxt    = out_res_r;
    pop            = 1'b0;
    raddr          = '0;
    // a copied cell lands in the cycle after its read
    we             = pend_r;
    waddr          = pend_addr_r;
    wdata          = rd_data_r;
    case (state_r)
      B_IDLE: begin
        if (!q_empty) begin
          pop     = 1'b1;
          cur_nxt = head;
          case (head.kind)
            K_READ: begin
              raddr     = head.addr;
              state_nxt = B_READ;
            end
            K_CLEAR: begin
              sw_nxt    = '0;
              state_nxt = B_CLEAR;
            end
            default: begin
              if (head.kind == K_WRITE) begin
                we    = 1'b1;
                waddr = head.addr;
                wdata = head.wdata;
              end
              if (head.scroll) begin
                sw_nxt    = '0;
                state_nxt = B_COPY;
              end else begin
                out_strobe_nxt = 1'b1;
                out_res_nxt    = '{head.row, head.col, '0, 1'b0};
              end
            end
          endcase
        end
      end
      B_READ: begin
        out_strobe_nxt = 1'b1;
        out_res_nxt    = '{cur_r.row, cur_r.col, rd_data_r, 1'b0};
        state_nxt      = B_IDLE;
      end
      B_CLEAR: begin
        we    = 1'b1;
        waddr = sw_r;
        wdata = blank;
        if (sw_r == IDX_W'(CELL_COUNT - 1)) begin
          out_strobe_nxt = 1'b1;
          out_res_nxt    = '{cur_r.row, cur_r.col, '0, 1'b0};
          state_nxt      = B_IDLE;
        end else begin
          sw_nxt = sw_r + 1'b1;
        end
      end
      B_COPY: begin
        raddr         = sw_r + IDX_W'(NUM_COLS);
        pend_nxt      = 1'b1;
        pend_addr_nxt = sw_r;
        sw_nxt        = sw_r + 1'b1;
        if (sw_r == IDX_W'(LAST_COPY)) begin
          state_nxt = B_BLANK;
        end
      end
      B_BLANK: begin
        // drain the last copied cell before blanking the bottom row
        if (!pend_r) begin
          we    = 1'b1;
          waddr = sw_r;
          wdata = blank;
          if (sw_r == IDX_W'(CELL_COUNT - 1)) begin
            out_strobe_nxt = 1'b1;
            out_res_nxt    = '{cur_r.row, cur_r.col, '0, 1'b1};
            state_nxt      = B_IDLE;
          end else begin
            sw_nxt = sw_r + 1'b1;
          end
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_data_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= B_IDLE;
      pend_r       <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      pend_r       <= pend_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
    cur_r       <= cur_nxt;
    sw_r        <= sw_nxt;
    pend_addr_r <= pend_addr_nxt;
    out_res_r   <= out_res_nxt;
  end

  a_pop_needs_entry: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_empty)
    else $error("pop from empty queue");

  a_copy_leaves_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_COPY) |=> (pend_r && !out_strobe_r))
    else $error("scroll copy lost a cell or emitted early");

  a_scroll_homes_last_row: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe_r && out_res_r.scrolled) |->
      (out_res_r.row_after == ROW_W'(NUM_ROWS - 1) && out_res_r.col_after == '0))
    else $error("scroll result with cursor off the last row start");

endmodule

`default_nettype wire

@@ tb/tb_text_console_cursor_engine.sv @@
// Self-checking testbench for the text console cursor engine: directed and random traffic.

module tb_text_console_cursor_engine;
  import tcce_pkg::*;

  // Command value that the block leaves unused; it must change nothing
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  // The slowest legal run is every item scrolling, plus sender gaps; allow
  // several times that before declaring a hang.
  localparam int unsigned CYCLE_LIMIT     = 16_000_000;
  localparam int unsigned REPORT_MAX      = 10;
  localparam int unsigned ITEMS_PER_CHUNK = 125;
  localparam int unsigned CHUNKS          = 4;
  localparam int unsigned SETTLE_CYCLES   = 8;
  localparam logic [IDX_W-1:0] IDX_MAX    = '1;

  // Screen and cursor predictor plus the queue of results still to arrive
  class console_scoreboard;
    logic [CELL_W-1:0] cells [CELL_COUNT];
    int unsigned       row_pos;
    int unsigned       col_pos;
    logic [ATTR_W-1:0] blank_attr;
    bit                screen_cleared;
    out_item_t         expected_q [$];
    int unsigned       mismatches;

    function new();
      foreach (cells[i]) cells[i] = '0;
      row_pos        = 0;
      col_pos        = 0;
      blank_attr     = DEFAULT_ATTR_RST;
      screen_cleared = 0;
      mismatches     = 0;
    endfunction

    function logic [CELL_W-1:0] blank_cell();
      return {blank_attr, CH_SPACE};
    endfunction

    function void write_cell(int unsigned r, int unsigned c, logic [CELL_W-1:0] v);
      int unsigned idx;
      idx = r * NUM_COLS + c;
      if (idx < CELL_COUNT) cells[idx] = v;
    endfunction

    // Interpret one character; return 1 when the screen scrolled
    function bit put_char(logic [CHAR_W-1:0] ch, logic [ATTR_W-1:0] color);
      case (ch)
        CH_LF: begin
          col_pos = 0;
          row_pos++;
        end
        CH_CR: col_pos = 0;
        CH_TAB: col_pos = (col_pos + TAB_STEP) & ~(TAB_STEP - 1);
        CH_BS: begin
          // nothing to step back over at the top-left corner
          if (row_pos != 0 || col_pos != 0) begin
            if (col_pos > 0) begin
              col_pos--;
            end else begin
              row_pos--;
              col_pos = NUM_COLS - 1;
            end
            write_cell(row_pos, col_pos, blank_cell());
          end
        end
        default: begin
          if (ch >= CH_SPACE && ch <= CH_LAST) begin
            write_cell(row_pos, col_pos, {color, ch});
            col_pos++;
          end
        end
      endcase
      if (col_pos >= NUM_COLS) begin
        col_pos = 0;
        row_pos++;
      end
      if (row_pos >= NUM_ROWS) begin
        for (int i = 0; i < CELL_COUNT; i++) begin
          if (i + NUM_COLS < CELL_COUNT) cells[i] = cells[i + NUM_COLS];
          else cells[i] = blank_cell();
        end
        row_pos = NUM_ROWS - 1;
        col_pos = 0;
        return 1;
      end
      return 0;
    endfunction

    function bit has_effect(in_item_t it);
      if (it.command == CMD_CLEAR || it.command == CMD_READ) return 1;
      if (it.command != CMD_PUT) return 0;
      return (it.char_code inside {CH_BS, CH_TAB, CH_LF, CH_CR}) ||
             (it.char_code >= CH_SPACE && it.char_code <= CH_LAST);
    endfunction

    // Advance the prediction by one accepted transaction
    function void note_input(in_item_t it);
      out_item_t want;
      want = '0;
      case (it.command)
        CMD_PUT: want.scrolled = put_char(it.char_code, it.color);
        CMD_CLEAR: begin
          foreach (cells[i]) cells[i] = blank_cell();
          row_pos        = 0;
          col_pos        = 0;
          screen_cleared = 1;
        end
        CMD_READ: begin
          if (it.cell_index < CELL_COUNT) want.cell_data = cells[it.cell_index];
        end
        default: ;
      endcase
      want.row_after = row_pos[ROW_W-1:0];
      want.col_after = col_pos[COL_W-1:0];
      expected_q.push_back(want);
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("%0t: unexpected result row %0d col %0d cell %h scrolled %0d",
                   $time, got.row_after, got.col_after, got.cell_data, got.scrolled);
        return;
      end
      want = expected_q.pop_front();
      if (got.row_after !== want.row_after || got.col_after !== want.col_after ||
          got.cell_data !== want.cell_data || got.scrolled !== want.scrolled) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display({"%0t: mismatch expected row %0d col %0d cell %h scrolled %0d, ",
                    "got row %0d col %0d cell %h scrolled %0d"},
                   $time, want.row_after, want.col_after, want.cell_data, want.scrolled,
                   got.row_after, got.col_after, got.cell_data, got.scrolled);
      end
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  logic              clk        = 1'b0;
  logic              rst_n      = 1'b0;
  logic              start      = 1'b0;
  logic              busy;
  in_item_t          in_item    = '0;
  logic              out_strobe;
  out_item_t         out_res;
  logic              cfg_valid  = 1'b0;
  logic              cfg_ready;
  logic [ATTR_W-1:0] cfg_data   = '0;

  int unsigned cycle_count = 0;
  int unsigned idle_pct    = 0;
  int unsigned items_sent  = 0;
  console_scoreboard console_sb = new();

  text_console_cursor_engine DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_strobe (out_strobe),
    .out_res    (out_res),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always #2 clk = ~clk;

  // Count cycles and stop a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Take every strobed result; the block cannot be held off
  always @(posedge clk) begin
    if (rst_n && out_strobe) console_sb.check_result(out_res);
  end

  // Offer one transaction, hold it until busy is low at an edge, then predict it.
  // Start stays high on return so back-to-back transactions need no extra edge.
  task automatic send_item(input logic [1:0] cmd, input logic [CHAR_W-1:0] ch,
                           input logic [ATTR_W-1:0] color, input logic [IDX_W-1:0] idx);
    in_item_t it;
    it = '{command: cmd, char_code: ch, color: color, cell_index: idx};
    // Keep reads away from cells that nothing has written yet
    if (cmd == CMD_READ && !console_sb.screen_cleared && idx < CELL_COUNT)
      it.cell_index = IDX_MAX;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start   <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    console_sb.note_input(it);
    if (console_sb.has_effect(it)) items_sent++;
  endtask

  // Drop start and wait until every expected result has come back
  task automatic drain();
    start <= 1'b0;
    while (console_sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_attr(input logic [ATTR_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    cfg_valid <= 1'b0;
    console_sb.blank_attr = value;
  endtask

  // One line of text: printable bytes with a sprinkling of tabs and backspaces,
  // mostly closed by a newline (sometimes carriage return first)
  task automatic type_line();
    int unsigned len;
    int unsigned ending;
    len = ($urandom_range(7) == 0) ? $urandom_range(100, 50) : $urandom_range(30);
    for (int unsigned k = 0; k < len; k++) begin
      if ($urandom_range(19) == 0)
        send_item(CMD_PUT, ($urandom_range(1) != 0) ? CH_TAB : CH_BS,
                  ATTR_W'($urandom_range(255)), IDX_W'($urandom_range(IDX_MAX)));
      else
        send_item(CMD_PUT, CHAR_W'($urandom_range(CH_LAST, CH_SPACE)),
                  ATTR_W'($urandom_range(255)), IDX_W'($urandom_range(IDX_MAX)));
    end
    ending = $urandom_range(99);
    if (ending < 15)
      send_item(CMD_PUT, CH_CR, ATTR_W'($urandom_range(255)), IDX_W'($urandom_range(IDX_MAX)));
    if (ending < 80)
      send_item(CMD_PUT, CH_LF, ATTR_W'($urandom_range(255)), IDX_W'($urandom_range(IDX_MAX)));
  endtask

  // Random traffic in chunks; change the blank attribute between chunks while idle
  task automatic random_phase(input int unsigned pct, input logic [ATTR_W-1:0] first_attr);
    int unsigned goal;
    int unsigned pick;
    logic [IDX_W-1:0] idx;
    idle_pct = pct;
    for (int unsigned c = 0; c < CHUNKS; c++) begin
      drain();
      write_attr((c == 0) ? first_attr : ATTR_W'($urandom_range(255)));
      goal = items_sent + ITEMS_PER_CHUNK;
      while (items_sent < goal) begin
        pick = $urandom_range(99);
        if (pick < 60) begin
          type_line();
        end else if (pick < 80) begin
          idx = ($urandom_range(7) == 0) ? IDX_W'($urandom_range(IDX_MAX, CELL_COUNT))
                                         : IDX_W'($urandom_range(CELL_COUNT - 1));
          send_item(CMD_READ, CHAR_W'($urandom_range(255)), ATTR_W'($urandom_range(255)),
                    idx);
        end else if (pick < 98) begin
          // noise: any byte, now and then the unused command
          send_item(($urandom_range(3) == 0) ? CMD_UNUSED : CMD_PUT,
                    CHAR_W'($urandom_range(255)), ATTR_W'($urandom_range(255)),
                    IDX_W'($urandom_range(IDX_MAX)));
        end else begin
          send_item(CMD_CLEAR, CHAR_W'($urandom_range(255)), ATTR_W'($urandom_range(255)),
                    IDX_W'($urandom_range(IDX_MAX)));
        end
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    idle_pct = 13;

    // Before any clear, with the reset attribute
    send_item(CMD_PUT, CH_BS, 8'h00, '0);           // backspace at home does nothing
    send_item(CMD_PUT, "A", 8'hFF, '0);
    send_item(CMD_READ, 8'h00, 8'h00, IDX_MAX);     // beyond the screen reads zero
    send_item(CMD_CLEAR, 8'hFF, 8'hFF, IDX_MAX);
    send_item(CMD_READ, 8'hFF, 8'h00, '0);          // blank cell with reset attribute
    send_item(CMD_PUT, CH_BS, 8'hFF, '0);
    send_item(CMD_PUT, CH_SPACE, 8'h00, '0);        // lowest printable, darkest color
    send_item(CMD_PUT, CH_LAST, 8'hFF, IDX_MAX);    // highest printable
    send_item(CMD_PUT, CH_TAB, 8'h00, '0);
    send_item(CMD_PUT, 8'h80, 8'h5A, '0);           // high bytes and other controls: ignored
    send_item(CMD_PUT, 8'hFF, 8'h5A, '0);
    send_item(CMD_PUT, 8'h1F, 8'h5A, '0);
    send_item(CMD_PUT, 8'h00, 8'h5A, '0);
    send_item(CMD_PUT, CH_CR, 8'h00, '0);
    send_item(CMD_PUT, CH_LF, 8'h00, '0);

    drain();
    write_attr(8'h00);
    send_item(CMD_PUT, CH_BS, 8'h00, '0);           // column 0 steps back to previous row end
    send_item(CMD_READ, 8'h00, 8'h00, IDX_W'(NUM_COLS - 1));
    send_item(CMD_PUT, "Z", 8'hA5, '0);             // last column wraps to next row
    send_item(CMD_PUT, CH_BS, 8'h00, '0);
    send_item(CMD_PUT, CH_TAB, 8'h00, '0);          // tab past the line end wraps
    send_item(CMD_READ, 8'h00, 8'h00, IDX_W'(CELL_COUNT - 1));
    send_item(CMD_READ, 8'h00, 8'h00, IDX_W'(CELL_COUNT));
    send_item(CMD_UNUSED, 8'hFF, 8'hFF, IDX_MAX);
    send_item(CMD_READ, 8'h00, 8'h00, IDX_W'(1));

    random_phase(13, 8'hFF);
    random_phase(87, 8'h00);
    random_phase(0, ATTR_W'($urandom_range(255)));

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (console_sb.mismatches == 0 && console_sb.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ text_console_cursor_engine.f @@
design/tcce_pkg.sv
design/tcce_front.sv
design/tcce_queue.sv
design/tcce_back.sv
design/text_console_cursor_engine.sv
tb/tb_text_console_cursor_engine.sv
